// ===== hdl/ppdr_pkg.sv =====
// Package for the planar pose dead reckoning core: CORDIC angle table,
// gain constant and the step record passed from front to back.
// No dependencies.
package ppdr_pkg;

   localparam int AngleTableLen = 24;
   localparam logic signed [31:0] CordicGainQ30 = 32'sd652032874;
   localparam logic signed [31:0] QuarterTurn = 32'sd1073741824;

   typedef struct packed {
      logic signed [33:0] rel_x;
      logic signed [33:0] rel_y;
      logic [15:0] yaw;
   } step_type;

   function automatic logic [29:0] angle_entry(input logic [4:0] i);
      logic [29:0] r;
      begin
         r = '0;
         case (i)
            5'd0: r = 30'd536870912;
            5'd1: r = 30'd316933406;
            5'd2: r = 30'd167458907;
            5'd3: r = 30'd85004756;
            5'd4: r = 30'd42667331;
            5'd5: r = 30'd21354465;
            5'd6: r = 30'd10679838;
            5'd7: r = 30'd5340245;
            5'd8: r = 30'd2670163;
            5'd9: r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

// ===== hdl/ppdr_front.sv =====
// Front end: takes a step, scales the offsets, forms the yaw vector from the
// quaternion and runs a vectoring CORDIC. Uses ppdr_pkg.
module ppdr_front #(
   parameter int Iterations = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [31:0] step_x,
   input  logic signed [31:0] step_y,
   input  logic signed [15:0] quat_x,
   input  logic signed [15:0] quat_y,
   input  logic signed [15:0] quat_z,
   input  logic signed [15:0] quat_w,
   input  logic signed [31:0] lateral_offset,
   output logic out_valid,
   input  logic out_ready,
   output ppdr_pkg::step_type out_step
);
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StMul = 2'd1;
   localparam logic [1:0] StRun = 2'd2;
   localparam logic [1:0] StDone = 2'd3;
   localparam int CntW = $clog2(Iterations + 1);

   logic [1:0] state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic signed [33:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [15:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in, qw_ff, qw_in;
   logic signed [35:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [33:0] z_ff, z_in;
   logic zero_ff, zero_in;
   logic signed [33:0] num, den;
   logic signed [35:0] nx, ny, sx, sy;
   logic signed [33:0] ang;
   logic signed [34:0] zr;

   always_comb begin
      num = 34'(2 * (34'(qw_ff) * 34'(qz_ff) + 34'(qx_ff) * 34'(qy_ff)));
      den = 34'(ppdr_pkg::QuarterTurn) -
            34'(2 * (34'(qy_ff) * 34'(qy_ff) + 34'(qz_ff) * 34'(qz_ff)));
   end

   always_comb begin
      sx = vx_ff >>> cnt_ff;
      sy = vy_ff >>> cnt_ff;
      ang = 34'(ppdr_pkg::angle_entry(5'(cnt_ff)));
      zr = 35'(z_ff) + 35'sd32768;
   end

   assign in_ready = (state_ff == StIdle);
   assign out_valid = (state_ff == StDone);
   assign out_step.rel_x = rx_ff;
   assign out_step.rel_y = ry_ff;
   assign out_step.yaw = zero_ff ? 16'd0 : zr[31:16];

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rx_in = rx_ff; ry_in = ry_ff;
      qx_in = qx_ff; qy_in = qy_ff; qz_in = qz_ff; qw_in = qw_ff;
      vx_in = vx_ff; vy_in = vy_ff; z_in = z_ff; zero_in = zero_ff;
      nx = '0; ny = '0;
      unique case (state_ff)
         StIdle: begin
            if (in_valid) begin
               rx_in = 34'(step_x) <<< 1;
               ry_in = (34'(step_y) <<< 1) + 34'(lateral_offset);
               qx_in = quat_x; qy_in = quat_y; qz_in = quat_z; qw_in = quat_w;
               state_in = StMul;
            end
         end
         StMul: begin
            cnt_in = '0;
            zero_in = (num == 0) && (den == 0);
            if (den < 0) begin
               if (num >= 0) begin
                  vy_in = -36'(den); vx_in = 36'(num);
                  z_in = 34'(ppdr_pkg::QuarterTurn);
               end else begin
                  vy_in = 36'(den); vx_in = -36'(num);
                  z_in = -34'(ppdr_pkg::QuarterTurn);
               end
            end else begin
               vx_in = 36'(den); vy_in = 36'(num); z_in = '0;
            end
            state_in = (Iterations == 0) ? StDone : StRun;
         end
         StRun: begin
            if (vy_ff > 0) begin
               nx = vx_ff + sy; ny = vy_ff - sx; z_in = z_ff + ang;
            end else begin
               nx = vx_ff - sy; ny = vy_ff + sx; z_in = z_ff - ang;
            end
            vx_in = nx; vy_in = ny;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(Iterations - 1)) state_in = StDone;
         end
         StDone: begin
            if (out_ready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      rx_ff <= rx_in; ry_ff <= ry_in;
      qx_ff <= qx_in; qy_ff <= qy_in; qz_ff <= qz_in; qw_ff <= qw_in;
      vx_ff <= vx_in; vy_ff <= vy_in; z_ff <= z_in; zero_ff <= zero_in;
   end
endmodule

// ===== hdl/ppdr_queue.sv =====
// Two-entry queue of step records between the front and back ends.
// Uses ppdr_pkg.
module ppdr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  ppdr_pkg::step_type wdata,
   input  logic pop,
   output logic empty,
   output ppdr_pkg::step_type rdata
);
   ppdr_pkg::step_type mem_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= !wp_ff;
         if (pop && !empty) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push && !full) - 2'(pop && !empty);
      end
   end
endmodule

// ===== hdl/ppdr_back.sv =====
// Back end: rotates the step by the stored heading, accumulates the pose and
// produces the half-heading quaternion with one shared rotation CORDIC.
// Uses ppdr_pkg.
module ppdr_back #(
   parameter int Iterations = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  ppdr_pkg::step_type in_step,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [31:0] pose_x,
   output logic signed [31:0] pose_y,
   output logic signed [15:0] pose_heading,
   output logic signed [15:0] heading_qz,
   output logic signed [15:0] heading_qw,
   output logic saturated
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StCor1 = 3'd1;
   localparam logic [2:0] StMul = 3'd2;
   localparam logic [2:0] StSum = 3'd3;
   localparam logic [2:0] StAcc = 3'd4;
   localparam logic [2:0] StCor2 = 3'd5;
   localparam logic [2:0] StOut = 3'd6;
   localparam int CntW = $clog2(Iterations + 1);

   logic [2:0] state_ff, state_in;
   logic [CntW-1:0] cnt_ff;
   logic start;
   logic signed [33:0] rx_ff, ry_ff;
   logic [15:0] yaw_ff;
   logic signed [31:0] acc_x_ff, acc_y_ff;
   logic [15:0] acc_h_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic [1:0] quad_ff;
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic signed [31:0] q_s_ff, q_c_ff;
   logic clip_ff;
   logic signed [33:0] c30, s30, c28, s28, sx, sy, ang;
   logic signed [64:0] ex, ey;
   logic signed [34:0] nx, ny;
   logic signed [31:0] sat_x, sat_y;
   logic signed [33:0] za;
   logic [15:0] nh;

   function automatic logic signed [15:0] q15(input logic signed [33:0] v);
      logic signed [34:0] r;
      begin
         r = (35'(v) + 35'sd16384) >>> 15;
         if (r > 35'sd32767) return 16'sd32767;
         if (r < -35'sd32768) return -16'sd32768;
         return r[15:0];
      end
   endfunction

   // Quadrant fold and final swap of the rotation CORDIC.
   always_comb begin
      unique case (quad_ff)
         2'd1: begin c30 = -cy_ff; s30 = cx_ff; end
         2'd2: begin c30 = cy_ff; s30 = -cx_ff; end
         default: begin c30 = cx_ff; s30 = cy_ff; end
      endcase
      c28 = (c30 + 34'sd2) >>> 2;
      s28 = (s30 + 34'sd2) >>> 2;
      sx = cx_ff >>> cnt_ff;
      sy = cy_ff >>> cnt_ff;
      ang = 34'(ppdr_pkg::angle_entry(5'(cnt_ff)));
      ex = (65'(p0_ff) - 65'(p1_ff) + 65'sd134217728) >>> 28;
      ey = (65'(p2_ff) + 65'(p3_ff) + 65'sd134217728) >>> 28;
      nx = 35'(acc_x_ff) + 35'(dx_ff);
      ny = 35'(acc_y_ff) + 35'(dy_ff);
      if (nx > 35'sd2147483647) sat_x = 32'sh7fffffff;
      else if (nx < -35'sd2147483648) sat_x = 32'sh80000000;
      else sat_x = nx[31:0];
      if (ny > 35'sd2147483647) sat_y = 32'sh7fffffff;
      else if (ny < -35'sd2147483648) sat_y = 32'sh80000000;
      else sat_y = ny[31:0];
   end

   assign start = (state_ff == StIdle) && in_valid;
   assign in_ready = (state_ff == StIdle);
   assign rsp_valid = (state_ff == StOut);
   assign pose_x = acc_x_ff;
   assign pose_y = acc_y_ff;
   assign pose_heading = acc_h_ff;
   assign heading_qz = q15(34'(q_s_ff));
   assign heading_qw = q15(34'(q_c_ff));
   assign saturated = clip_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: if (in_valid) state_in = StCor1;
         StCor1: if (cnt_ff == CntW'(Iterations)) state_in = StMul;
         StMul: state_in = StSum;
         StSum: state_in = StAcc;
         StAcc: state_in = StCor2;
         StCor2: if (cnt_ff == CntW'(Iterations)) state_in = StOut;
         StOut: if (rsp_ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         acc_h_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (start || (state_ff == StAcc)) cnt_ff <= '0;
         else if ((state_ff == StCor1 || state_ff == StCor2)
                  && cnt_ff != CntW'(Iterations)) cnt_ff <= cnt_ff + 1'b1;
         if (state_ff == StAcc) begin
            acc_x_ff <= sat_x;
            acc_y_ff <= sat_y;
            acc_h_ff <= acc_h_ff + yaw_ff;
         end
      end
   end

   // The first rotation uses the stored heading; the second uses half of the
   // new heading, sign-extended into a 32-bit binary angle.
   always_comb begin
      nh = acc_h_ff + yaw_ff;
      if (state_ff == StIdle) za = 34'(signed'({acc_h_ff, 16'd0}));
      else za = 34'(signed'({nh[15], nh, 15'd0}));
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rx_ff <= in_step.rel_x;
         ry_ff <= in_step.rel_y;
         yaw_ff <= in_step.yaw;
      end
      if (start || state_ff == StAcc) begin
         cx_ff <= 34'(ppdr_pkg::CordicGainQ30);
         cy_ff <= '0;
         if (za >= 34'(ppdr_pkg::QuarterTurn)) begin
            cz_ff <= za - 34'(ppdr_pkg::QuarterTurn); quad_ff <= 2'd1;
         end else if (za < -34'(ppdr_pkg::QuarterTurn)) begin
            cz_ff <= za + 34'(ppdr_pkg::QuarterTurn); quad_ff <= 2'd2;
         end else begin
            cz_ff <= za; quad_ff <= 2'd0;
         end
      end else if ((state_ff == StCor1 || state_ff == StCor2)
                   && cnt_ff != CntW'(Iterations)) begin
         if (cz_ff >= 0) begin
            cx_ff <= cx_ff - sy; cy_ff <= cy_ff + sx; cz_ff <= cz_ff - ang;
         end else begin
            cx_ff <= cx_ff + sy; cy_ff <= cy_ff - sx; cz_ff <= cz_ff + ang;
         end
      end
      if (state_ff == StMul) begin
         p0_ff <= 64'(rx_ff) * 64'(c28);
         p1_ff <= 64'(ry_ff) * 64'(s28);
         p2_ff <= 64'(rx_ff) * 64'(s28);
         p3_ff <= 64'(ry_ff) * 64'(c28);
      end
      if (state_ff == StSum) begin
         dx_ff <= ex[33:0];
         dy_ff <= ey[33:0];
      end
      if (state_ff == StAcc) begin
         clip_ff <= (nx > 35'sd2147483647) || (nx < -35'sd2147483648) ||
                    (ny > 35'sd2147483647) || (ny < -35'sd2147483648);
      end
      if (state_ff == StCor2 && cnt_ff == CntW'(Iterations)) begin
         q_s_ff <= s30[31:0];
         q_c_ff <= c30[31:0];
      end
   end
endmodule

// ===== hdl/planar_pose_dead_reckoning_core.sv =====
// Planar pose dead reckoning core. Each step passes through the front end,
// which runs the yaw vectoring CORDIC before handing the record to a
// two-entry queue; the back end then picks it up and performs the heading
// rotation, the position update and the half-heading rotation through one
// shared rotation CORDIC. Neither end takes a new step before it is through
// with the last one, but the queue lets the next yaw be computed while the
// back end still works. A result that is not popped stalls the back end and,
// once the queue fills, the input. Position saturates to 32 bits.
// Uses ppdr_pkg, ppdr_front, ppdr_queue and ppdr_back.
module planar_pose_dead_reckoning_core #(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic signed [31:0] req_step_x,
   input  logic signed [31:0] req_step_y,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic empty,
   input  logic pop,
   output logic signed [31:0] rsp_pose_x,
   output logic signed [31:0] rsp_pose_y,
   output logic signed [15:0] rsp_pose_heading,
   output logic signed [15:0] rsp_heading_qz,
   output logic signed [15:0] rsp_heading_qw,
   output logic rsp_saturated,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic signed [31:0] csr_lateral_offset
);
   logic signed [31:0] lat_ff;
   logic f_ready, f_valid, q_full, q_empty, b_ready, b_valid;
   ppdr_pkg::step_type f_step, q_step;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) lat_ff <= '0;
      else if (csr_valid) lat_ff <= csr_lateral_offset;
   end

   assign full = !f_ready;
   assign empty = !b_valid;

   ppdr_front #(.Iterations(CORDIC_ITERATIONS)) u_front (
      .clock, .reset,
      .in_valid(push), .in_ready(f_ready),
      .step_x(req_step_x), .step_y(req_step_y),
      .quat_x(req_quat_x), .quat_y(req_quat_y),
      .quat_z(req_quat_z), .quat_w(req_quat_w),
      .lateral_offset(lat_ff),
      .out_valid(f_valid), .out_ready(!q_full), .out_step(f_step)
   );

   ppdr_queue u_queue (
      .clock, .reset,
      .push(f_valid), .full(q_full), .wdata(f_step),
      .pop(b_ready), .empty(q_empty), .rdata(q_step)
   );

   ppdr_back #(.Iterations(CORDIC_ITERATIONS)) u_back (
      .clock, .reset,
      .in_valid(!q_empty), .in_ready(b_ready), .in_step(q_step),
      .rsp_valid(b_valid), .rsp_ready(pop),
      .pose_x(rsp_pose_x), .pose_y(rsp_pose_y),
      .pose_heading(rsp_pose_heading),
      .heading_qz(rsp_heading_qz), .heading_qw(rsp_heading_qw),
      .saturated(rsp_saturated)
   );
endmodule
